// ===== rtl/bwlp_pkg.sv =====
package bwlp_pkg;

  // Block configuration
  localparam int MAX_DIM        = 4096;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int RATIO_FRAC     = 16;

  // Field widths
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int CUT_W    = 16;
  localparam int ORD_W    = 6;
  localparam int CFG_W    = 16;
  localparam int CFG_AW   = 3;
  localparam int GAIN_W   = GAIN_FRAC_BITS + 1;

  // Datapath widths
  localparam int HALF_W   = $clog2(MAX_DIM);
  localparam int DIST_W   = (HALF_W > COORD_W) ? HALF_W : COORD_W;
  localparam int SQ_W     = 2 * DIST_W;
  localparam int D2_W     = SQ_W + 1;
  localparam int C2_W     = 2 * CUT_W;
  localparam int NUM_W    = D2_W + 8 + RATIO_FRAC + 1;
  localparam int RQ_W     = GAIN_FRAC_BITS + 1 + RATIO_FRAC;
  localparam int DCMP_W   = C2_W + RQ_W;
  localparam int X_W      = GAIN_FRAC_BITS + RATIO_FRAC + 2;
  localparam int RLO_W    = RATIO_FRAC;
  localparam int RHI_W    = RQ_W - RLO_W;
  localparam int PLO_W    = X_W + RLO_W;
  localparam int PHI_W    = X_W + RHI_W;
  localparam int PROD_W   = X_W + RQ_W;
  localparam int DEN_W    = X_W + 1;
  localparam int RCMP_W   = DEN_W + GAIN_W;
  localparam int N_ITER   = (1 << ORD_W) - 1;

  // Fixed-point constants
  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_HALF = GAIN_W'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [X_W-1:0]    X_ONE     = X_W'(1) << RATIO_FRAC;
  localparam logic [PROD_W-1:0] PROD_THR  = PROD_W'(1) << (GAIN_FRAC_BITS + 1 + 2 * RATIO_FRAC);
  localparam logic [PROD_W-1:0] PROD_RND  = PROD_W'(1) << (RATIO_FRAC - 1);
  localparam logic [DEN_W-1:0]  RECIP_NUM = DEN_W'(1) << (GAIN_FRAC_BITS + RATIO_FRAC);

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_ROWS   = 3'd0,
    REG_COLS   = 3'd1,
    REG_CUTOFF = 3'd2,
    REG_ORDER  = 3'd3,
    REG_KIND   = 3'd4
  } cfg_reg_t;

  localparam logic KIND_IDEAL = 1'b1;

  // Gain that bypasses the Butterworth path (ideal mode, zero cutoff)
  typedef struct packed {
    logic              force_gain;
    logic [GAIN_W-1:0] fixed_gain;
  } side_t;

endpackage

// ===== rtl/bwlp_if.sv =====
interface bwlp_in_if;
  import bwlp_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  modport source (output valid, row, col, input ready);
  modport sink   (input valid, row, col, output ready);
endinterface

interface bwlp_out_if;
  import bwlp_pkg::*;
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] gain;
  modport source (output valid, gain, input ready);
  modport sink   (input valid, gain, output ready);
endinterface

// ===== rtl/bwlp_front.sv =====
module bwlp_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           valid_i,
  input  logic [bwlp_pkg::COORD_W-1:0]   row_i,
  input  logic [bwlp_pkg::COORD_W-1:0]   col_i,
  input  logic [bwlp_pkg::HALF_W-1:0]    half_row,
  input  logic [bwlp_pkg::HALF_W-1:0]    half_col,
  input  logic [bwlp_pkg::C2_W-1:0]      c2,
  input  logic                           kind,
  output logic                           valid_o,
  output logic [bwlp_pkg::NUM_W-1:0]     num_o,
  output bwlp_pkg::side_t                side_o
);
  import bwlp_pkg::*;

  logic [DIST_W-1:0] row_e, col_e, hr_e, hc_e;
  logic              v1_r, v2_r, v3_r;
  logic [DIST_W-1:0] dr_r, dc_r;
  logic [SQ_W-1:0]   dr2_r, dc2_r;
  logic [D2_W-1:0]   d2;
  logic [NUM_W-1:0]  num_r;
  side_t             side_nxt, side_r;

  assign row_e = DIST_W'(row_i);
  assign col_e = DIST_W'(col_i);
  assign hr_e  = DIST_W'(half_row);
  assign hc_e  = DIST_W'(half_col);
  assign d2    = D2_W'(dr2_r) + D2_W'(dc2_r);

  // bypass gain for ideal mode and zero cutoff
  always_comb begin
    side_nxt = '0;
    if (kind == KIND_IDEAL) begin
      side_nxt.force_gain = 1'b1;
      side_nxt.fixed_gain = ((C2_W + 9)'(d2) << 8) <= (C2_W + 9)'(c2) ? GAIN_ONE : '0;
    end else if (c2 == '0) begin
      side_nxt.force_gain = 1'b1;
      side_nxt.fixed_gain = (d2 == '0) ? GAIN_ONE : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      // stage 1: distances to centre
      v1_r  <= valid_i;
      dr_r  <= (row_e >= hr_e) ? row_e - hr_e : hr_e - row_e;
      dc_r  <= (col_e >= hc_e) ? col_e - hc_e : hc_e - col_e;
      // stage 2: squares
      v2_r  <= v1_r;
      dr2_r <= dr_r * dr_r;
      dc2_r <= dc_r * dc_r;
      // stage 3: ratio numerator with rounding term
      v3_r  <= v2_r;
      num_r <= (NUM_W'(d2) << (8 + RATIO_FRAC)) + NUM_W'(c2 >> 1);
      side_r <= side_nxt;
    end
  end

  assign valid_o = v3_r;
  assign num_o   = num_r;
  assign side_o  = side_r;

endmodule

// ===== rtl/bwlp_ratio_div.sv =====
module bwlp_ratio_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         valid_i,
  input  logic [bwlp_pkg::NUM_W-1:0]   num_i,
  input  bwlp_pkg::side_t              side_i,
  input  logic [bwlp_pkg::C2_W-1:0]    c2,
  output logic                         valid_o,
  output logic [bwlp_pkg::RQ_W-1:0]    ratio_o,
  output logic                         ovf_o,
  output bwlp_pkg::side_t              side_o
);
  import bwlp_pkg::*;

  logic [NUM_W-1:0] rem_r  [0:RQ_W];
  logic [RQ_W-1:0]  q_r    [0:RQ_W];
  logic             v_r    [0:RQ_W];
  logic             ovf_r  [0:RQ_W];
  side_t            side_r [0:RQ_W];

  // entry stage: quotient range check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0]    <= valid_i;
      rem_r[0]  <= num_i;
      q_r[0]    <= '0;
      ovf_r[0]  <= DCMP_W'(num_i) >= (DCMP_W'(c2) << RQ_W);
      side_r[0] <= side_i;
    end
  end

  // one restoring quotient bit per stage, MSB first
  for (genvar s = 0; s < RQ_W; s++) begin : g_bit
    localparam int B = RQ_W - 1 - s;
    logic [DCMP_W-1:0] dsh;
    logic              take;
    assign dsh  = DCMP_W'(c2) << B;
    assign take = DCMP_W'(rem_r[s]) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1]    <= v_r[s];
        rem_r[s+1]  <= take ? rem_r[s] - NUM_W'(dsh) : rem_r[s];
        q_r[s+1]    <= take ? (q_r[s] | (RQ_W'(1) << B)) : q_r[s];
        ovf_r[s+1]  <= ovf_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign valid_o = v_r[RQ_W];
  assign ratio_o = q_r[RQ_W];
  assign ovf_o   = ovf_r[RQ_W];
  assign side_o  = side_r[RQ_W];

endmodule

// ===== rtl/bwlp_power.sv =====
module bwlp_power (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_i,
  input  logic [bwlp_pkg::RQ_W-1:0]     ratio_i,
  input  logic                          ovf_i,
  input  bwlp_pkg::side_t               side_i,
  input  logic [bwlp_pkg::ORD_W-1:0]    order,
  output logic                          valid_o,
  output logic [bwlp_pkg::X_W-1:0]      x_o,
  output logic                          sat_o,
  output bwlp_pkg::side_t               side_o
);
  import bwlp_pkg::*;

  // iteration inputs: index 0 is the module input
  logic [X_W-1:0]   x_s    [0:N_ITER];
  logic [RQ_W-1:0]  r_s    [0:N_ITER];
  logic             sat_s  [0:N_ITER];
  logic             v_s    [0:N_ITER];
  side_t            side_s [0:N_ITER];

  always_comb begin
    x_s[0]    = X_ONE;
    r_s[0]    = ratio_i;
    sat_s[0]  = ovf_i && (order != '0);
    v_s[0]    = valid_i;
    side_s[0] = side_i;
  end

  for (genvar j = 0; j < N_ITER; j++) begin : g_iter
    logic [PLO_W-1:0]  plo_r;
    logic [PHI_W-1:0]  phi_r;
    logic [X_W-1:0]    xa_r;
    logic [RQ_W-1:0]   ra_r;
    logic              sata_r, va_r;
    side_t             sidea_r;
    logic              active;
    logic [PROD_W-1:0] prod, prod_rnd;
    logic              sat_nxt;
    logic [X_W-1:0]    x_nxt;

    assign active   = ORD_W'(j) < order;
    assign prod     = (PROD_W'(phi_r) << RLO_W) + PROD_W'(plo_r);
    assign prod_rnd = prod + PROD_RND;

    // active steps saturate once x*r hits the limit, else round it
    always_comb begin
      sat_nxt = sata_r;
      x_nxt   = xa_r;
      if (active) begin
        if (sata_r || (prod >= PROD_THR)) begin
          sat_nxt = 1'b1;
          x_nxt   = '0;
        end else begin
          x_nxt = X_W'(prod_rnd >> RATIO_FRAC);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r     <= 1'b0;
        v_s[j+1] <= 1'b0;
      end else if (en) begin
        // partial products
        va_r        <= v_s[j];
        plo_r       <= x_s[j] * r_s[j][RLO_W-1:0];
        phi_r       <= x_s[j] * r_s[j][RQ_W-1:RLO_W];
        xa_r        <= x_s[j];
        ra_r        <= r_s[j];
        sata_r      <= sat_s[j];
        sidea_r     <= side_s[j];
        // sum, check and round
        v_s[j+1]    <= va_r;
        x_s[j+1]    <= x_nxt;
        r_s[j+1]    <= ra_r;
        sat_s[j+1]  <= sat_nxt;
        side_s[j+1] <= sidea_r;
      end
    end
  end

  assign valid_o = v_s[N_ITER];
  assign x_o     = x_s[N_ITER];
  assign sat_o   = sat_s[N_ITER];
  assign side_o  = side_s[N_ITER];

endmodule

// ===== rtl/bwlp_recip.sv =====
module bwlp_recip (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_i,
  input  logic [bwlp_pkg::X_W-1:0]      x_i,
  input  logic                          sat_i,
  input  bwlp_pkg::side_t               side_i,
  output logic                          valid_o,
  output logic [bwlp_pkg::GAIN_W-1:0]   gain_o,
  output logic                          sat_o,
  output bwlp_pkg::side_t               side_o
);
  import bwlp_pkg::*;

  logic [DEN_W-1:0]  den_in;
  logic [DEN_W-1:0]  den_r  [0:GAIN_W];
  logic [DEN_W-1:0]  rem_r  [0:GAIN_W];
  logic [GAIN_W-1:0] q_r    [0:GAIN_W];
  logic              v_r    [0:GAIN_W];
  logic              sat_r  [0:GAIN_W];
  side_t             side_r [0:GAIN_W];

  assign den_in = DEN_W'(X_ONE) + DEN_W'(x_i);

  // entry stage: denominator 1+x and rounded numerator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0]    <= valid_i;
      den_r[0]  <= den_in;
      rem_r[0]  <= RECIP_NUM + (den_in >> 1);
      q_r[0]    <= '0;
      sat_r[0]  <= sat_i;
      side_r[0] <= side_i;
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < GAIN_W; s++) begin : g_bit
    localparam int B = GAIN_W - 1 - s;
    logic [RCMP_W-1:0] dsh;
    logic              take;
    assign dsh  = RCMP_W'(den_r[s]) << B;
    assign take = RCMP_W'(rem_r[s]) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1]    <= v_r[s];
        den_r[s+1]  <= den_r[s];
        rem_r[s+1]  <= take ? rem_r[s] - DEN_W'(dsh) : rem_r[s];
        q_r[s+1]    <= take ? (q_r[s] | (GAIN_W'(1) << B)) : q_r[s];
        sat_r[s+1]  <= sat_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign valid_o = v_r[GAIN_W];
  assign gain_o  = q_r[GAIN_W];
  assign sat_o   = sat_r[GAIN_W];
  assign side_o  = side_r[GAIN_W];

endmodule

// ===== rtl/butterworth_lowpass_gain.sv =====
// Low-pass frequency mask: one (row, col) request in, one Q1.16 gain out, one
// request accepted every clock while the output side keeps taking results.
// The pipe runs through distance and squaring, the pipelined restoring ratio divider
// (d/D0)^2, the 63 two-stage multiply steps of the power loop (one step per
// possible order, unused ones pass through), the 1/(1+x) reciprocal divider and
// the output register. The whole pipe stalls together while a result waits at
// the output. Configuration writes take effect through the configuration
// registers (the cutoff also through its squared copy) and must be made with the pipe empty.
module butterworth_lowpass_gain (
  input  logic                          clk,
  input  logic                          rst_n,
  bwlp_in_if.sink                       in_chan,
  bwlp_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic [bwlp_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [bwlp_pkg::CFG_W-1:0]    cfg_wdata
);
  import bwlp_pkg::*;

  logic [DIM_W-1:0]  rows_r, cols_r;
  logic [CUT_W-1:0]  cutoff_r;
  logic [ORD_W-1:0]  order_r;
  logic              kind_r;
  logic [C2_W-1:0]   c2_r;
  logic [HALF_W-1:0] half_row, half_col;
  logic              en;

  logic              fr_valid;
  logic [NUM_W-1:0]  fr_num;
  side_t             fr_side;
  logic              dv_valid, dv_ovf;
  logic [RQ_W-1:0]   dv_ratio;
  side_t             dv_side;
  logic              pw_valid, pw_sat;
  logic [X_W-1:0]    pw_x;
  side_t             pw_side;
  logic              rc_valid, rc_sat;
  logic [GAIN_W-1:0] rc_gain;
  side_t             rc_side;

  logic              out_valid_r;
  logic [GAIN_W-1:0] gain_r, gain_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= DIM_W'(512);
      cols_r   <= DIM_W'(512);
      cutoff_r <= CUT_W'(1600);
      order_r  <= ORD_W'(2);
      kind_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ROWS:   rows_r   <= cfg_wdata[DIM_W-1:0];
        REG_COLS:   cols_r   <= cfg_wdata[DIM_W-1:0];
        REG_CUTOFF: cutoff_r <= cfg_wdata[CUT_W-1:0];
        REG_ORDER:  order_r  <= cfg_wdata[ORD_W-1:0];
        REG_KIND:   kind_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // squared cutoff, derived from the register
  always_ff @(posedge clk) begin
    c2_r <= cutoff_r * cutoff_r;
  end

  // plane centre, dimensions clamped to the maximum
  assign half_row = (rows_r > DIM_W'(MAX_DIM)) ? HALF_W'(MAX_DIM >> 1) : HALF_W'(rows_r >> 1);
  assign half_col = (cols_r > DIM_W'(MAX_DIM)) ? HALF_W'(MAX_DIM >> 1) : HALF_W'(cols_r >> 1);

  // global advance
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  bwlp_front u_front (
    .clk, .rst_n, .en,
    .valid_i  (in_chan.valid),
    .row_i    (in_chan.row),
    .col_i    (in_chan.col),
    .half_row (half_row),
    .half_col (half_col),
    .c2       (c2_r),
    .kind     (kind_r),
    .valid_o  (fr_valid),
    .num_o    (fr_num),
    .side_o   (fr_side)
  );

  bwlp_ratio_div u_div (
    .clk, .rst_n, .en,
    .valid_i (fr_valid),
    .num_i   (fr_num),
    .side_i  (fr_side),
    .c2      (c2_r),
    .valid_o (dv_valid),
    .ratio_o (dv_ratio),
    .ovf_o   (dv_ovf),
    .side_o  (dv_side)
  );

  bwlp_power u_power (
    .clk, .rst_n, .en,
    .valid_i (dv_valid),
    .ratio_i (dv_ratio),
    .ovf_i   (dv_ovf),
    .side_i  (dv_side),
    .order   (order_r),
    .valid_o (pw_valid),
    .x_o     (pw_x),
    .sat_o   (pw_sat),
    .side_o  (pw_side)
  );

  bwlp_recip u_recip (
    .clk, .rst_n, .en,
    .valid_i (pw_valid),
    .x_i     (pw_x),
    .sat_i   (pw_sat),
    .side_i  (pw_side),
    .valid_o (rc_valid),
    .gain_o  (rc_gain),
    .sat_o   (rc_sat),
    .side_o  (rc_side)
  );

  // final gain selection
  always_comb begin
    if (rc_side.force_gain) begin
      gain_nxt = rc_side.fixed_gain;
    end else if (rc_sat) begin
      gain_nxt = '0;
    end else begin
      gain_nxt = rc_gain;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rc_valid;
      gain_r      <= gain_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.gain  = gain_r;

`ifndef NO_ASSERTIONS
  // gain never exceeds 1.0
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> gain_r <= GAIN_ONE)
    else $error("gain above one");

  // ideal mode gives only 0 or 1.0
  a_ideal_binary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_IDEAL) |-> (gain_r == '0 || gain_r == GAIN_ONE))
    else $error("ideal gain not binary");

  // zero order with nonzero cutoff gives one half
  a_order_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r != KIND_IDEAL && order_r == '0 && c2_r != '0
     && $stable(order_r) && $stable(kind_r)) |-> gain_r == GAIN_HALF)
    else $error("zero order gain not one half");
`endif

endmodule
